// ===== rtl/mpool_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, register map and a helper function for the 2-D max pooling block.
// No dependencies; imported by max_pool_2d_argmax_top and the testbench.
package mpool_pkg;

  // Default sizing of the top-level parameters
  localparam int MPOOL_MAX_ROWS   = 256;
  localparam int MPOOL_MAX_COLS   = 256;
  localparam int MPOOL_MAX_FACTOR = 16;
  localparam int MPOOL_DATA_WIDTH = 16;

  // Register field widths
  localparam int ROWS_W   = 9;
  localparam int COLS_W   = 9;
  localparam int CHANS_W  = 11;
  localparam int FACTOR_W = 5;
  localparam int CFG_W    = 11;   // widest register
  localparam int CFG_IDX_W = 3;

  // Result field widths
  localparam int POS_W   = 16;
  localparam int PLANE_W = 10;

  localparam int CHANNEL_LIMIT = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_INDEX = 3'd5;

  // Register reset values
  localparam logic [ROWS_W-1:0]   RST_IN_ROWS    = 9'd28;
  localparam logic [COLS_W-1:0]   RST_IN_COLS    = 9'd28;
  localparam logic [CHANS_W-1:0]  RST_CHANNELS   = 11'd1;
  localparam logic [FACTOR_W-1:0] RST_ROW_FACTOR = 5'd2;
  localparam logic [FACTOR_W-1:0] RST_COL_FACTOR = 5'd2;

  // Saturate a size register into 1..hi
  function automatic logic [31:0] mp_clamp(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] res;
    res = v;
    if (v < 32'd1) res = 32'd1;
    else if (v > hi) res = hi;
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/max_pool_2d_argmax_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming 2-D max pooling with argmax, stride equal to window, valid padding.
// A result passes the update-stage and result registers before it shows on out_tdata.
// Throughput: one element per cycle unless busy or stalled by out_tready; the partial-max
//   memory is read on accept, written from the update stage, forwarding same-column hits.
// Reset (rst_n low, synchronous) and every register write start a shared serial divider
//   that derives the output grid and window position; in_tready stays low while it runs.
module max_pool_2d_argmax_top
  import mpool_pkg::*;
#(
  parameter int MAX_ROWS   = MPOOL_MAX_ROWS,
  parameter int MAX_COLS   = MPOOL_MAX_COLS,
  parameter int MAX_FACTOR = MPOOL_MAX_FACTOR,
  parameter int DATA_WIDTH = MPOOL_DATA_WIDTH,
  localparam int ITW = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OFW = DATA_WIDTH + POS_W + POS_W + PLANE_W,
  localparam int OTW = ((OFW + 7) / 8) * 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration write port
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_wdata,
  // input stream
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [ITW-1:0]        in_tdata,   // sample_value
  // result stream
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [OTW-1:0]       out_tdata,  // max_value, max_index, out_position, plane_number
  output logic                 out_tlast   // last_of_sample
);

  // Widths derived from the sizing parameters
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;     // row position
  localparam int RCW  = $clog2(MAX_ROWS + 1);                      // row count
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;     // column position
  localparam int CCW  = $clog2(MAX_COLS + 1);                      // column count
  localparam int FW   = $clog2(MAX_FACTOR + 1);                    // factor value
  localparam int FRW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1; // offset inside a window
  localparam int DVW  = (RCW > CCW) ? RCW : CCW;                   // divider dividend
  localparam int SW   = $clog2(DVW + 1);
  localparam int MW   = DATA_WIDTH + POS_W;                        // memory word: {pos, value}

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ROWS_W-1:0]   cfg_rows_r;
  logic [COLS_W-1:0]   cfg_cols_r;
  logic [CHANS_W-1:0]  cfg_chans_r;
  logic [FACTOR_W-1:0] cfg_rf_r;
  logic [FACTOR_W-1:0] cfg_cf_r;
  logic                cfg_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r  <= RST_IN_ROWS;
      cfg_cols_r  <= RST_IN_COLS;
      cfg_chans_r <= RST_CHANNELS;
      cfg_rf_r    <= RST_ROW_FACTOR;
      cfg_cf_r    <= RST_COL_FACTOR;
      cfg_emit_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IN_ROWS:    cfg_rows_r  <= cfg_wdata[ROWS_W-1:0];
        CFG_IN_COLS:    cfg_cols_r  <= cfg_wdata[COLS_W-1:0];
        CFG_CHANNELS:   cfg_chans_r <= cfg_wdata[CHANS_W-1:0];
        CFG_ROW_FACTOR: cfg_rf_r    <= cfg_wdata[FACTOR_W-1:0];
        CFG_COL_FACTOR: cfg_cf_r    <= cfg_wdata[FACTOR_W-1:0];
        CFG_EMIT_INDEX: cfg_emit_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturated sizes: zero acts as one, oversize acts as the maximum
  logic [RCW-1:0]     rows_c;
  logic [CCW-1:0]     cols_c;
  logic [CHANS_W-1:0] chs_c;
  logic [FW-1:0]      rf_c;
  logic [FW-1:0]      cf_c;

  assign rows_c = RCW'(mp_clamp(32'(cfg_rows_r), 32'(MAX_ROWS)));
  assign cols_c = CCW'(mp_clamp(32'(cfg_cols_r), 32'(MAX_COLS)));
  assign chs_c  = CHANS_W'(mp_clamp(32'(cfg_chans_r), 32'(CHANNEL_LIMIT)));
  assign rf_c   = FW'(mp_clamp(32'(cfg_rf_r), 32'(MAX_FACTOR)));
  assign cf_c   = FW'(mp_clamp(32'(cfg_cf_r), 32'(MAX_FACTOR)));

  // ---------------------------------------------------------------------------
  // Serial divider: derives the output grid size and the current window
  // coordinates (quotient and remainder of the raster position).
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {DV_IDLE, DV_LOAD, DV_RUN, DV_STORE} dv_state_t;
  typedef enum logic [1:0] {JOB_OUT_ROWS, JOB_OUT_COLS, JOB_ROW_POS, JOB_COL_POS} dv_job_t;

  dv_state_t      dv_state_r;
  dv_job_t        dv_job_r;
  logic [SW-1:0]  dv_step_r;
  logic [FW-1:0]  dv_rem_r;
  logic [DVW-1:0] dv_quo_r;

  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;

  logic [DVW-1:0] dv_dividend;
  logic [FW-1:0]  dv_divisor;
  logic [FW:0]    dv_trial;
  logic           dv_ge;
  logic [FW:0]    dv_diff;
  logic [FW-1:0]  dv_rem_nxt;
  logic [DVW-1:0] dv_quo_nxt;
  logic           busy;

  always_comb begin
    case (dv_job_r)
      JOB_OUT_ROWS: dv_dividend = DVW'(rows_c);
      JOB_OUT_COLS: dv_dividend = DVW'(cols_c);
      JOB_ROW_POS:  dv_dividend = DVW'(row_r);
      JOB_COL_POS:  dv_dividend = DVW'(col_r);
      default:      dv_dividend = '0;
    endcase
    dv_divisor = (dv_job_r == JOB_OUT_COLS || dv_job_r == JOB_COL_POS) ? cf_c : rf_c;
    // one restoring step: shift in the next dividend bit, subtract if it fits
    dv_trial   = {dv_rem_r, dv_quo_r[DVW-1]};
    dv_ge      = dv_trial >= {1'b0, dv_divisor};
    dv_diff    = dv_trial - {1'b0, dv_divisor};
    dv_rem_nxt = dv_ge ? dv_diff[FW-1:0] : dv_trial[FW-1:0];
    dv_quo_nxt = (dv_quo_r << 1) | DVW'(dv_ge);
  end

  assign busy = (dv_state_r != DV_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_state_r <= DV_LOAD;
      dv_job_r   <= JOB_OUT_ROWS;
    end else if (cfg_we) begin
      // restart the whole derivation on any register write
      dv_state_r <= DV_LOAD;
      dv_job_r   <= JOB_OUT_ROWS;
    end else begin
      case (dv_state_r)
        DV_LOAD: begin
          dv_quo_r   <= dv_dividend;
          dv_rem_r   <= '0;
          dv_step_r  <= '0;
          dv_state_r <= DV_RUN;
        end
        DV_RUN: begin
          dv_quo_r  <= dv_quo_nxt;
          dv_rem_r  <= dv_rem_nxt;
          dv_step_r <= dv_step_r + SW'(1);
          if (dv_step_r == SW'(DVW - 1)) dv_state_r <= DV_STORE;
        end
        DV_STORE: begin
          if (dv_job_r == JOB_COL_POS) begin
            dv_state_r <= DV_IDLE;
          end else begin
            dv_job_r   <= dv_job_t'(dv_job_r + 2'd1);
            dv_state_r <= DV_LOAD;
          end
        end
        default: dv_state_r <= DV_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Raster counters
  // ---------------------------------------------------------------------------
  logic [PLANE_W-1:0] plane_r;
  logic [FRW-1:0]     iwr_r, iwc_r;      // offset inside the window, as the stream counts it
  logic [RW-1:0]      orow_r;            // row_r / rf
  logic [FRW-1:0]     rrem_r;            // row_r % rf
  logic [CW-1:0]      oc_r;              // col_r / cf
  logic [FRW-1:0]     crem_r;            // col_r % cf
  logic [RCW-1:0]     out_rows_r;
  logic [CCW-1:0]     out_cols_r;

  logic [RW-1:0]      row_nxt, orow_nxt;
  logic [CW-1:0]      col_nxt, oc_nxt;
  logic [PLANE_W-1:0] plane_nxt;
  logic [FRW-1:0]     iwr_nxt, iwc_nxt, rrem_nxt, crem_nxt;
  logic               col_wrap, row_wrap, plane_wrap;
  logic               in_accept;

  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    plane_nxt = plane_r;
    iwr_nxt   = iwr_r;
    iwc_nxt   = iwc_r;
    orow_nxt  = orow_r;
    rrem_nxt  = rrem_r;
    oc_nxt    = oc_r;
    crem_nxt  = crem_r;
    col_wrap   = (32'(col_r) + 32'd1) >= 32'(cols_c);
    row_wrap   = (32'(row_r) + 32'd1) >= 32'(rows_c);
    plane_wrap = (32'(plane_r) + 32'd1) >= 32'(chs_c);
    if (col_wrap) begin
      col_nxt  = '0;
      iwc_nxt  = '0;
      oc_nxt   = '0;
      crem_nxt = '0;
      if (row_wrap) begin
        row_nxt   = '0;
        iwr_nxt   = '0;
        orow_nxt  = '0;
        rrem_nxt  = '0;
        plane_nxt = plane_wrap ? '0 : plane_r + PLANE_W'(1);
      end else begin
        row_nxt = row_r + RW'(1);
        iwr_nxt = ((32'(iwr_r) + 32'd1) >= 32'(rf_c)) ? '0 : iwr_r + FRW'(1);
        if ((32'(rrem_r) + 32'd1) >= 32'(rf_c)) begin
          rrem_nxt = '0;
          orow_nxt = orow_r + RW'(1);
        end else begin
          rrem_nxt = rrem_r + FRW'(1);
        end
      end
    end else begin
      col_nxt = col_r + CW'(1);
      iwc_nxt = ((32'(iwc_r) + 32'd1) >= 32'(cf_c)) ? '0 : iwc_r + FRW'(1);
      if ((32'(crem_r) + 32'd1) >= 32'(cf_c)) begin
        crem_nxt = '0;
        oc_nxt   = oc_r + CW'(1);
      end else begin
        crem_nxt = crem_r + FRW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      plane_r <= '0;
      iwr_r   <= '0;
      iwc_r   <= '0;
      orow_r  <= '0;
      rrem_r  <= '0;
      oc_r    <= '0;
      crem_r  <= '0;
    end else if (dv_state_r == DV_STORE) begin
      // take the divider results
      case (dv_job_r)
        JOB_OUT_ROWS: out_rows_r <= RCW'(dv_quo_r);
        JOB_OUT_COLS: out_cols_r <= CCW'(dv_quo_r);
        JOB_ROW_POS: begin
          orow_r <= RW'(dv_quo_r);
          rrem_r <= FRW'(dv_rem_r);
        end
        JOB_COL_POS: begin
          oc_r   <= CW'(dv_quo_r);
          crem_r <= FRW'(dv_rem_r);
        end
        default: ;
      endcase
    end else if (in_accept) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      plane_r <= plane_nxt;
      iwr_r   <= iwr_nxt;
      iwc_r   <= iwc_nxt;
      orow_r  <= orow_nxt;
      rrem_r  <= rrem_nxt;
      oc_r    <= oc_nxt;
      crem_r  <= crem_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: classify the element, compute its in-plane index, read the partial max
  // ---------------------------------------------------------------------------
  logic        a_hit, a_seed, a_emit, a_last;
  logic [31:0] a_pos_full;

  assign a_hit  = (32'(orow_r) < 32'(out_rows_r)) && (32'(oc_r) < 32'(out_cols_r));
  assign a_seed = (iwr_r == '0) && (iwc_r == '0);
  assign a_emit = (32'(iwr_r) == 32'(rf_c) - 32'd1) && (32'(iwc_r) == 32'(cf_c) - 32'd1);
  assign a_last = (32'(plane_r) == 32'(chs_c) - 32'd1) &&
                  (32'(orow_r) == 32'(out_rows_r) - 32'd1) &&
                  (32'(oc_r) == 32'(out_cols_r) - 32'd1);
  assign a_pos_full = 32'(row_r) * 32'(cols_c) + 32'(col_r);

  // ---------------------------------------------------------------------------
  // Update stage: compare against the partial max, write back, hand off result
  // ---------------------------------------------------------------------------
  logic                         b_valid_r;
  logic signed [DATA_WIDTH-1:0] b_val_r;
  logic [POS_W-1:0]             b_pos_r;
  logic                         b_seed_r, b_emit_r, b_hit_r, b_last_r;
  logic [RW-1:0]                b_orow_r;
  logic [CW-1:0]                b_oc_r;
  logic [PLANE_W-1:0]           b_plane_r;
  logic                         b_fwd_r;
  logic [MW-1:0]                b_fwd_word_r;
  logic [MW-1:0]                rd_word_r;

  logic [MW-1:0]                pm_mem [MAX_COLS];

  logic [MW-1:0]                b_old_word;
  logic signed [DATA_WIDTH-1:0] b_old_val;
  logic                         b_take;
  logic [MW-1:0]                b_new_word;
  logic                         b_out, b_go, mem_we;
  logic [31:0]                  b_opos_full;

  // out_valid_r / out_*_r are the result register
  logic               out_valid_r;
  logic [OTW-1:0]     out_data_r;
  logic               out_last_r;

  always_comb begin
    // a write to the same column at the read edge wins over the stale read
    b_old_word = b_fwd_r ? b_fwd_word_r : rd_word_r;
    b_old_val  = b_old_word[DATA_WIDTH-1:0];
    b_take     = b_seed_r || (b_val_r > b_old_val);
    b_new_word = b_take ? {b_pos_r, b_val_r} : b_old_word;
    b_out      = b_hit_r && b_emit_r;
    b_go       = b_valid_r && (!b_out || !out_valid_r || out_tready);
    mem_we     = b_go && b_hit_r;
    b_opos_full = 32'(b_orow_r) * 32'(out_cols_r) + 32'(b_oc_r);
  end

  assign in_tready = !busy && (!b_valid_r || b_go);

  always_ff @(posedge clk) begin
    if (mem_we) pm_mem[b_oc_r] <= b_new_word;
    if (in_accept) rd_word_r <= pm_mem[oc_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_accept) begin
      b_valid_r <= 1'b1;
    end else if (b_go) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_val_r      <= in_tdata[DATA_WIDTH-1:0];
      b_pos_r      <= a_pos_full[POS_W-1:0];
      b_seed_r     <= a_seed;
      b_emit_r     <= a_emit;
      b_hit_r      <= a_hit;
      b_last_r     <= a_last;
      b_orow_r     <= orow_r;
      b_oc_r       <= oc_r;
      b_plane_r    <= plane_r;
      b_fwd_r      <= mem_we && (b_oc_r == oc_r);
      b_fwd_word_r <= b_new_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go && b_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_out) begin
      out_data_r <= OTW'({b_plane_r,
                          b_opos_full[POS_W-1:0],
                          cfg_emit_r ? b_new_word[MW-1:DATA_WIDTH] : {POS_W{1'b0}},
                          b_new_word[DATA_WIDTH-1:0]});
      out_last_r <= b_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_pool_2d_argmax_top: streams Q8.8 samples through the
// pooling block under many plane and window shapes and checks every pooled word.
// Depends on mpool_pkg and max_pool_2d_argmax_top from the RTL tree.
module tb;
  import mpool_pkg::*;

  localparam int IN_W  = 16;
  localparam int OUT_W = 64;

  // One pooled word as the block reports it
  typedef struct packed {
    logic [15:0] max_value;
    logic [15:0] max_index;
    logic [15:0] out_position;
    logic [9:0]  plane_number;
    logic        last_of_sample;
  } pool_result_t;

  // Directed stimulus row: sample word, and a hand-written result where one is obvious
  typedef struct packed {
    logic [15:0]  value;
    logic         typed;
    pool_result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;    // sample_value
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;   // max_value, max_index, out_position, plane_number
  logic                 out_tlast;   // last_of_sample

  max_pool_2d_argmax_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 20 ns period, first rising edge at 10 ns
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the size registers as last written
  int unsigned cur_rows  = RST_IN_ROWS;
  int unsigned cur_cols  = RST_IN_COLS;
  int unsigned cur_chans = RST_CHANNELS;
  int unsigned cur_rf    = RST_ROW_FACTOR;
  int unsigned cur_cf    = RST_COL_FACTOR;
  bit          cur_emit  = 1'b0;

  // Raster position of the next sample and position inside the current window
  int unsigned row_cnt = 0, col_cnt = 0, plane_cnt = 0, win_row = 0, win_col = 0;

  // Running maximum and its in-plane index, one entry per output column
  logic signed [15:0] part_max [MPOOL_MAX_COLS];
  logic [15:0]        part_pos [MPOOL_MAX_COLS];

  pool_result_t pending_maxima [$];

  bit calm = 1'b0;          // no idling on either side once set
  int fail_count   = 0;
  int results_seen = 0;
  int words_in     = 0;
  int settings_run = 0;

  // Directed part: rows=2, cols=5, channels=2, 2x2 windows, index reporting on.
  // Column 4 of every row falls outside the last whole window and is dropped.
  // Plane 0 has an all-minimum window (tie keeps index 0) and a window whose
  // maximum 7FFF shows up twice (tie keeps the earlier index 3). Plane 1 mixes
  // -1/0/+1 around zero; its second window closes the sample and raises last.
  dir_row_t dir_tab [20] = '{
    '{16'h8000, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h0100, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h1234, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h8000, 1'b1, '{16'h8000, 16'd0, 16'd0, 10'd0, 1'b0}},
    '{16'h7FFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, '{16'h7FFF, 16'd3, 16'd1, 10'd0, 1'b0}},
    '{16'h5555, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h00AA, 1'b0, '0},
    '{16'h0055, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'h0000, 1'b1, '{16'h0001, 16'd5, 16'd0, 10'd1, 1'b0}},
    '{16'hFF00, 1'b0, '0},
    '{16'h8000, 1'b1, '{16'h00AA, 16'd2, 16'd1, 10'd1, 1'b1}},
    '{16'hAAAA, 1'b0, '0}
  };

  // Zero acts as one, anything above the limit acts as the limit
  function automatic int unsigned sat_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Fold one sample into the window state; return 1 and the pooled word when a
  // window closes. Advances the raster position like the block does.
  function automatic bit pool_predict(input logic [15:0] raw, output pool_result_t r);
    int unsigned rows, cols, chs, rf, cf, out_rows, out_cols, oc, orow;
    logic signed [15:0] v;
    bit hit;
    rows     = sat_size(cur_rows, MPOOL_MAX_ROWS);
    cols     = sat_size(cur_cols, MPOOL_MAX_COLS);
    chs      = sat_size(cur_chans, CHANNEL_LIMIT);
    rf       = sat_size(cur_rf, MPOOL_MAX_FACTOR);
    cf       = sat_size(cur_cf, MPOOL_MAX_FACTOR);
    out_rows = rows / rf;
    out_cols = cols / cf;
    v        = raw;
    hit      = 1'b0;
    r        = '0;
    if (row_cnt < out_rows * rf && col_cnt < out_cols * cf) begin
      oc   = col_cnt / cf;
      orow = row_cnt / rf;
      // first element seeds, later ones replace only when strictly greater
      if ((win_row == 0 && win_col == 0) || v > part_max[oc]) begin
        part_max[oc] = v;
        part_pos[oc] = 16'(row_cnt * cols + col_cnt);
      end
      if (win_row == rf - 1 && win_col == cf - 1) begin
        r.max_value      = part_max[oc];
        r.max_index      = cur_emit ? part_pos[oc] : 16'd0;
        r.out_position   = 16'(orow * out_cols + oc);
        r.plane_number   = plane_cnt[9:0];
        r.last_of_sample = (plane_cnt == chs - 1 && orow == out_rows - 1 &&
                            oc == out_cols - 1);
        hit = 1'b1;
      end
    end
    // counters beyond a new, smaller bound wrap on this advance
    if (col_cnt + 1 >= cols) begin
      col_cnt = 0;
      win_col = 0;
      if (row_cnt + 1 >= rows) begin
        row_cnt   = 0;
        win_row   = 0;
        plane_cnt = (plane_cnt + 1 >= chs) ? 0 : plane_cnt + 1;
      end else begin
        row_cnt++;
        win_row = (win_row + 1 >= rf) ? 0 : win_row + 1;
      end
    end else begin
      col_cnt++;
      win_col = (win_col + 1 >= cf) ? 0 : win_col + 1;
    end
    return hit;
  endfunction

  // Write one register and mirror it into the shadow copy
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_IN_ROWS:    cur_rows  = data[ROWS_W-1:0];
      CFG_IN_COLS:    cur_cols  = data[COLS_W-1:0];
      CFG_CHANNELS:   cur_chans = data[CHANS_W-1:0];
      CFG_ROW_FACTOR: cur_rf    = data[FACTOR_W-1:0];
      CFG_COL_FACTOR: cur_cf    = data[FACTOR_W-1:0];
      CFG_EMIT_INDEX: cur_emit  = data[0];
      default: ;
    endcase
  endtask

  // Drain the block, then load a full register set back to back
  task automatic reconfigure(input int unsigned rows, input int unsigned cols,
                             input int unsigned chans, input int unsigned rf,
                             input int unsigned cf, input bit emit);
    in_tvalid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
    // words that close no window leave nothing to wait on; allow the pipeline to empty
    repeat (6) @(posedge clk);
    cfg_write(CFG_IN_ROWS, rows);
    cfg_write(CFG_IN_COLS, cols);
    cfg_write(CFG_CHANNELS, chans);
    cfg_write(CFG_ROW_FACTOR, rf);
    cfg_write(CFG_COL_FACTOR, cf);
    cfg_write(CFG_EMIT_INDEX, emit);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Predict, then offer one word until the block takes it. Entered and left
  // right after a rising edge.
  task automatic feed_word(input logic [15:0] v, input bit typed, input pool_result_t want);
    pool_result_t pred;
    bit got;
    got = pool_predict(v, pred);
    if (typed) pending_maxima.push_back(want);
    else if (got) pending_maxima.push_back(pred);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    words_in++;
  endtask

  // Load a setting and stream n random words; ties and extremes show up often
  task automatic run_phase(input int unsigned rows, input int unsigned cols,
                           input int unsigned chans, input int unsigned rf,
                           input int unsigned cf, input bit emit, input int n);
    logic [15:0] v, last_v;
    last_v = 16'h0000;
    reconfigure(rows, cols, chans, rf, cf, emit);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = last_v;
        default: v = 16'($urandom);
      endcase
      last_v = v;
      feed_word(v, 1'b0, '0);
    end
  endtask

  // Result side: hold tready low in random bursts until the calm tail
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    pool_result_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.max_value      = out_tdata[15:0];
      seen.max_index      = out_tdata[31:16];
      seen.out_position   = out_tdata[47:32];
      seen.plane_number   = out_tdata[57:48];
      seen.last_of_sample = out_tlast;
      results_seen++;
      if (pending_maxima.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected word max=%h idx=%0d pos=%0d plane=%0d last=%b", $realtime,
                   seen.max_value, seen.max_index, seen.out_position, seen.plane_number,
                   seen.last_of_sample);
        fail_count++;
      end else begin
        want = pending_maxima.pop_front();
        if (seen.max_value !== want.max_value || seen.max_index !== want.max_index ||
            seen.out_position !== want.out_position ||
            seen.plane_number !== want.plane_number ||
            seen.last_of_sample !== want.last_of_sample) begin
          if (fail_count < 10)
            $display("%0t: mismatch exp max=%h idx=%0d pos=%0d plane=%0d last=%b | got max=%h idx=%0d pos=%0d plane=%0d last=%b",
                     $realtime, want.max_value, want.max_index, want.out_position,
                     want.plane_number, want.last_of_sample, seen.max_value,
                     seen.max_index, seen.out_position, seen.plane_number,
                     seen.last_of_sample);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case the stream hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned rows, cols, chans, plane;
    int n, rand_words, guard;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    foreach (part_max[i]) begin
      part_max[i] = '0;
      part_pos[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: walk the table, typed rows override the predictor
    reconfigure(2, 5, 2, 2, 2, 1'b1);
    foreach (dir_tab[i]) feed_word(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);

    // One full-width 1x1 pass seeds every column entry, so later mid-sample
    // setting changes never read an entry that was never written
    run_phase(1, 256, 1, 1, 1, 1'b1, 256);

    // Clamped sizes: rows/channels/row factor of zero act as one, 511 columns
    // act as 256, column factor 31 acts as 16
    run_phase(0, 511, 0, 0, 31, 1'b1, 256);
    // Tallest plane with 16-row windows, index reporting off
    run_phase(256, 1, 1, 16, 1, 1'b0, 256);
    // Channel count above the limit: 1024 single-pixel planes, plane number tops out
    run_phase(1, 1, 2047, 1, 1, 1'b1, 1024);
    // Largest window, one result per sample
    run_phase(16, 16, 1, 16, 16, 1'b1, 256);
    // Window taller than the plane: words are swallowed, nothing comes out
    run_phase(3, 5, 3, 4, 2, 1'b1, 45);
    // Oversized row count, stopped partway so the next setting lands mid-sample
    run_phase(511, 2, 1, 2, 2, 1'b1, 300);

    // Random shapes, mostly whole samples, some cut short; quiet tail at the end
    rand_words = 0;
    while (rand_words < 450) begin
      rows  = $urandom_range(1, 12);
      cols  = $urandom_range(1, 12);
      chans = $urandom_range(1, 4);
      plane = rows * cols * chans;
      n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, plane))
                                      : int'(plane * $urandom_range(1, 2));
      if (rand_words >= 300) calm = 1'b1;
      run_phase(rows, cols, chans, $urandom_range(1, 4), $urandom_range(1, 4),
                1'(($urandom_range(0, 1))), n);
      rand_words += n;
    end

    // Drain with a bound, then give the pipeline a few more edges
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_maxima.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_maxima.size() != 0) begin
      $display("%0d expected words never arrived", pending_maxima.size());
      fail_count += pending_maxima.size();
    end

    $display("Streamed %0d samples over %0d register settings, checked %0d pooled words.",
             words_in, settings_run, results_seen);
    $display("Shapes included clamped sizes, oversize windows and mid-sample setting changes.");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
